FILE: design/gbsa_pkg.sv
// Shared types, codes and default sizes for the gather backward scatter-add unit.
// Depends on nothing; imported by the top level and the testbench.
package gbsa_pkg;

  localparam int ACC_DEPTH_DEF   = 4096;
  localparam int INDEX_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the interface.
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int ICNT_W  = 9;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 13;
  localparam int DIM_MAX = 4096;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_LOAD  = 2'd1,
    FN_GRAD  = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SKIP = 2'd1,
    STAT_SAT  = 2'd2,
    STAT_ADDR = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    REG_OUTER = 2'd0,
    REG_AXIS  = 2'd1,
    REG_INDEX = 2'd2,
    REG_INNER = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDX,
    ST_MUL,
    ST_CHK,
    ST_ACC,
    ST_RD,
    ST_DONE
  } state_t;

  // A dimension register of zero counts as one, and anything above the
  // maximum counts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > DIM_MAX) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/gbsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; used for every memory of the unit.
module gbsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gather_backward_scatter_add_unit.sv
// Top level of the gather backward scatter-add unit: control sequencer,
// address arithmetic, saturating accumulate and the output register.
// Depends on gbsa_pkg and gbsa_ram.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | func, position, index_value, grad_value
//  result   | out_valid / out_stall  | read_data, status
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Items are handled one at a time by a sequencer around two memories with a
// registered read. A load goes straight to completion, a read via ST_RD, and a
// gradient element via ST_IDX (index table read), ST_MUL (address from two
// multiplies), ST_CHK (accumulator read) and ST_ACC (write). A start item sweeps
// the accumulator to zero at one entry per cycle; the same sweep runs after reset,
// during which in_stall stays high. Reset is synchronous and active high.
// A finished result sits in an output register, so the next item is taken
// while out_stall holds the previous beat; only a second result waits for it.
// The configuration port is always ready.
module gather_backward_scatter_add_unit #(
  parameter int ACC_DEPTH   = gbsa_pkg::ACC_DEPTH_DEF,
  parameter int INDEX_DEPTH = gbsa_pkg::INDEX_DEPTH_DEF,
  parameter int VALUE_WIDTH = gbsa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input item channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [gbsa_pkg::CNT_W-1:0]   position,
  input  logic signed [gbsa_pkg::DATA_W-1:0] index_value,
  input  logic signed [gbsa_pkg::DATA_W-1:0] grad_value,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [gbsa_pkg::DATA_W-1:0] read_data,
  output logic [1:0]                   status,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [gbsa_pkg::CFG_W-1:0]   cfg_data
);

  import gbsa_pkg::*;

  localparam int ACC_AW = $clog2(ACC_DEPTH);
  localparam int IDX_AW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int IC_MAX = (INDEX_DEPTH < DIM_MAX) ? INDEX_DEPTH : DIM_MAX;
  // Sum width: wide enough for an entry plus a 32-bit gradient without overflow.
  localparam int SW     = ((VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W) + 1;
  localparam int BASE_W = 26;
  localparam int ADDR_W = 40;

  localparam logic signed [SW-1:0] VMAX = {{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = {{(SW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] I32MAX = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] I32MIN = {{(SW-31){1'b1}}, {31{1'b0}}};
  localparam logic [DATA_W-1:0] D32MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] D32MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration registers and their clamped views.
  logic [DIM_W-1:0]  outer_count, axis_size, inner_count;
  logic [ICNT_W-1:0] index_count;
  logic [DIM_W-1:0]  oc, ax, nc;
  logic [ICNT_W-1:0] ic;

  // Sequencer and position counters.
  state_t            state, state_next;
  logic [ACC_AW-1:0] clr_addr;
  logic              clr_res;
  logic [CNT_W-1:0]  inner_pos, outer_pos, cur_inner;
  logic [IDX_AW-1:0] slot_pos;

  // Datapath registers.
  logic [DATA_W-1:0] grad_r;
  logic [24:0]       prod;
  logic [BASE_W-1:0] base;
  logic [ADDR_W-1:0] addr_full;
  logic [DATA_W-1:0] res_data;
  stat_t             res_status;
  logic [DATA_W-1:0] out_data;
  stat_t             out_status;

  // Memory ports.
  logic                   tbl_we, tbl_re;
  logic [IDX_AW-1:0]      tbl_waddr;
  logic [DATA_W-1:0]      tbl_rdata;
  logic                   acc_we, acc_re;
  logic [ACC_AW-1:0]      acc_waddr, acc_raddr;
  logic [VALUE_WIDTH-1:0] acc_wdata, acc_rdata;

  // Combinational helpers.
  logic              accept, out_load;
  logic [31:0]       pos_ext, slot_inc;
  logic              pos_in_tbl, pos_in_acc, idx_ok, addr_ok;
  logic signed [SW-1:0] acc_ext, grad_ext, sum;
  logic [VALUE_WIDTH-1:0] sum_sat;
  logic              sum_clamped;
  logic [DATA_W-1:0] rd_sat;
  logic              rd_clamped;

  assign oc = clamp_dim(outer_count);
  assign ax = clamp_dim(axis_size);
  assign nc = clamp_dim(inner_count);

  always_comb begin
    if (index_count == '0) begin
      ic = ICNT_W'(1);
    end else if (32'(index_count) > IC_MAX) begin
      ic = ICNT_W'(IC_MAX);
    end else begin
      ic = index_count;
    end
  end

  assign accept     = in_valid && !in_stall;
  assign out_load   = !out_valid || !out_stall;
  assign pos_ext    = 32'(position);
  assign pos_in_tbl = pos_ext < 32'(INDEX_DEPTH);
  assign pos_in_acc = pos_ext < 32'(ACC_DEPTH);
  assign slot_inc   = 32'(slot_pos) + 32'd1;
  assign tbl_waddr  = pos_ext[IDX_AW-1:0];

  // The stored index is in range when it is not negative and below the axis.
  assign idx_ok  = !tbl_rdata[DATA_W-1] && (tbl_rdata[DATA_W-2:0] < 31'(ax));
  assign addr_ok = 64'(addr_full) < 64'(ACC_DEPTH);

  // Saturating accumulate and the clamp of a read to 32 bits.
  always_comb begin
    acc_ext  = SW'(signed'(acc_rdata));
    grad_ext = SW'(signed'(grad_r));
    sum      = acc_ext + grad_ext;
    if (sum > VMAX) begin
      sum_sat     = VMAX[VALUE_WIDTH-1:0];
      sum_clamped = 1'b1;
    end else if (sum < VMIN) begin
      sum_sat     = VMIN[VALUE_WIDTH-1:0];
      sum_clamped = 1'b1;
    end else begin
      sum_sat     = sum[VALUE_WIDTH-1:0];
      sum_clamped = 1'b0;
    end
    if (acc_ext > I32MAX) begin
      rd_sat     = D32MAX;
      rd_clamped = 1'b1;
    end else if (acc_ext < I32MIN) begin
      rd_sat     = D32MIN;
      rd_clamped = 1'b1;
    end else begin
      rd_sat     = acc_ext[DATA_W-1:0];
      rd_clamped = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ACC_AW'(ACC_DEPTH - 1)) begin
          state_next = clr_res ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FN_START: state_next = ST_CLEAR;
            FN_LOAD:  state_next = ST_DONE;
            FN_GRAD:  state_next = ST_IDX;
            FN_READ:  state_next = pos_in_acc ? ST_RD : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_IDX:  state_next = idx_ok ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = ST_CHK;
      ST_CHK:  state_next = addr_ok ? ST_ACC : ST_DONE;
      ST_ACC:  state_next = ST_DONE;
      ST_RD:   state_next = ST_DONE;
      ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    cfg_ready = 1'b1;
    tbl_we    = accept && (func == FN_LOAD) && pos_in_tbl;
    tbl_re    = accept && (func == FN_GRAD);
    acc_we    = 1'b0;
    acc_waddr = clr_addr;
    acc_wdata = '0;
    acc_re    = 1'b0;
    acc_raddr = pos_ext[ACC_AW-1:0];
    case (state)
      ST_CLEAR: begin
        acc_we = 1'b1;
      end
      ST_IDLE: begin
        acc_re = accept && (func == FN_READ) && pos_in_acc;
      end
      ST_CHK: begin
        acc_re    = addr_ok;
        acc_raddr = addr_full[ACC_AW-1:0];
      end
      ST_ACC: begin
        acc_we    = 1'b1;
        acc_waddr = addr_full[ACC_AW-1:0];
        acc_wdata = sum_sat;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  // Sequencer state, counters and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      clr_res     <= 1'b0;
      inner_pos   <= '0;
      slot_pos    <= '0;
      outer_pos   <= '0;
      out_valid   <= 1'b0;
      outer_count <= DIM_W'(1);
      axis_size   <= DIM_W'(1);
      index_count <= ICNT_W'(1);
      inner_count <= DIM_W'(1);
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUTER: outer_count <= cfg_data;
          REG_AXIS:  axis_size   <= cfg_data;
          REG_INDEX: index_count <= cfg_data[ICNT_W-1:0];
          REG_INNER: inner_count <= cfg_data;
          default:   outer_count <= outer_count;
        endcase
      end

      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ACC_AW'(1);
      end

      if (accept && (func == FN_START)) begin
        clr_addr  <= '0;
        clr_res   <= 1'b1;
        inner_pos <= '0;
        slot_pos  <= '0;
        outer_pos <= '0;
      end else if (accept && (func == FN_GRAD)) begin
        // Inner position runs fastest, then the index slot, then outer.
        if (32'(inner_pos) + 32'd1 >= 32'(nc)) begin
          inner_pos <= '0;
          if (slot_inc >= 32'(ic)) begin
            slot_pos <= '0;
            if (32'(outer_pos) + 32'd1 >= 32'(oc)) begin
              outer_pos <= '0;
            end else begin
              outer_pos <= outer_pos + CNT_W'(1);
            end
          end else begin
            slot_pos <= slot_pos + IDX_AW'(1);
          end
        end else begin
          inner_pos <= inner_pos + CNT_W'(1);
        end
      end

      if ((state == ST_DONE) && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Address arithmetic and result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          grad_r     <= grad_value;
          cur_inner  <= inner_pos;
          prod       <= {13'b0, outer_pos} * {12'b0, ax};
          res_data   <= '0;
          if (((func == FN_LOAD) && !pos_in_tbl) ||
              ((func == FN_READ) && !pos_in_acc)) begin
            res_status <= STAT_ADDR;
          end else begin
            res_status <= STAT_OK;
          end
        end
      end
      ST_IDX: begin
        base <= {1'b0, prod} + {13'b0, tbl_rdata[DIM_W-1:0]};
        if (!idx_ok) begin
          res_status <= STAT_SKIP;
        end
      end
      ST_MUL: begin
        addr_full <= {14'b0, base} * {27'b0, nc} + {28'b0, cur_inner};
      end
      ST_CHK: begin
        if (!addr_ok) begin
          res_status <= STAT_ADDR;
        end
      end
      ST_ACC: begin
        if (sum_clamped) begin
          res_status <= STAT_SAT;
        end
      end
      ST_RD: begin
        res_data <= rd_sat;
        if (rd_clamped) begin
          res_status <= STAT_SAT;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_data   <= res_data;
          out_status <= res_status;
        end
      end
      default: begin
        res_data <= res_data;
      end
    endcase
  end

  assign read_data = out_data;
  assign status    = out_status;

  gbsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (INDEX_DEPTH)
  ) u_index_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (index_value),
    .re    (tbl_re),
    .raddr (slot_pos),
    .rdata (tbl_rdata)
  );

  gbsa_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ACC_DEPTH)
  ) u_accumulator (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: an accepted item holds off the next one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item still in work");

  // Accumulator writes stay inside the memory.
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> (32'(acc_waddr) < 32'(ACC_DEPTH)))
    else $error("accumulator write beyond depth");

  // The sequencer never reads and writes the accumulator in one cycle.
  a_acc_port: assert property (@(posedge clk) disable iff (rst)
    !(acc_we && acc_re))
    else $error("accumulator read and write overlap");

  // A new result beat comes only from the completion step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion step");
`endif

endmodule

FILE: tb/gbsa_tb_pkg.sv
// Scoreboard for the gather backward scatter-add testbench.
// It models the unit one item at a time and checks result beats in order.
// Depends on gbsa_pkg.
`timescale 1ns / 1ps
package gbsa_tb_pkg;
  import gbsa_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    stat_t                    stat;
  } result_beat_t;

  class scatter_add_board;
    logic signed [DATA_W-1:0] accum [ACC_DEPTH_DEF];
    logic signed [DATA_W-1:0] gather_index [INDEX_DEPTH_DEF];
    bit                       index_loaded [INDEX_DEPTH_DEF];
    logic [CFG_W-1:0]         dim_reg [4];
    longint                   inner_at, slot_at, outer_at;
    result_beat_t             due_beats [$];
    int                       failures;

    function new();
      foreach (accum[i]) accum[i] = '0;
      foreach (gather_index[i]) gather_index[i] = '0;
      foreach (index_loaded[i]) index_loaded[i] = 1'b0;
      foreach (dim_reg[i]) dim_reg[i] = CFG_W'(1);
      inner_at = 0;
      slot_at = 0;
      outer_at = 0;
      failures = 0;
    endfunction

    // The index count register only keeps its low nine bits.
    function void set_reg(reg_t r, logic [CFG_W-1:0] v);
      dim_reg[r] = (r == REG_INDEX) ? CFG_W'(v[ICNT_W-1:0]) : v;
    endfunction

    // Effective dimension: zero counts as one, oversize counts as the maximum.
    function longint dim(reg_t r);
      longint v, hi;
      v = dim_reg[r];
      hi = (r == REG_INDEX) ? INDEX_DEPTH_DEF : DIM_MAX;
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function bit slot_ready();
      return index_loaded[slot_at];
    endfunction

    function longint cur_slot();
      return slot_at;
    endfunction

    function int outstanding();
      return due_beats.size();
    endfunction

    function void note_item(func_t f, logic [CNT_W-1:0] pos,
                            logic signed [DATA_W-1:0] ival,
                            logic signed [DATA_W-1:0] grad);
      result_beat_t beat;
      logic signed [DATA_W:0] sum;
      longint idx, addr, oc, ax, ic, nc;
      beat.data = '0;
      beat.stat = STAT_OK;
      oc = dim(REG_OUTER);
      ax = dim(REG_AXIS);
      ic = dim(REG_INDEX);
      nc = dim(REG_INNER);
      case (f)
        FN_START: begin
          foreach (accum[i]) accum[i] = '0;
          inner_at = 0;
          slot_at = 0;
          outer_at = 0;
        end
        FN_LOAD: begin
          if (pos < INDEX_DEPTH_DEF) begin
            gather_index[pos] = ival;
            index_loaded[pos] = 1'b1;
          end else begin
            beat.stat = STAT_ADDR;
          end
        end
        FN_GRAD: begin
          idx = gather_index[slot_at];
          if (idx < 0 || idx >= ax) begin
            beat.stat = STAT_SKIP;
          end else begin
            addr = (outer_at * ax + idx) * nc + inner_at;
            if (addr >= ACC_DEPTH_DEF) begin
              beat.stat = STAT_ADDR;
            end else begin
              sum = accum[addr] + grad;
              if (sum[DATA_W] != sum[DATA_W-1]) begin
                // The true sum left the range; clamp toward its sign.
                accum[addr] = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
                beat.stat = STAT_SAT;
              end else begin
                accum[addr] = sum[DATA_W-1:0];
              end
            end
          end
          inner_at++;
          if (inner_at >= nc) begin
            inner_at = 0;
            slot_at++;
            if (slot_at >= ic) begin
              slot_at = 0;
              outer_at++;
              if (outer_at >= oc) outer_at = 0;
            end
          end
        end
        default: begin
          if (pos < ACC_DEPTH_DEF) beat.data = accum[pos];
          else beat.stat = STAT_ADDR;
        end
      endcase
      due_beats.push_back(beat);
    endfunction

    function void record_fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [1:0] stat);
      result_beat_t want;
      if (due_beats.size() == 0) begin
        record_fail($sformatf("unexpected result beat: data %h status %0d", data, stat));
        return;
      end
      want = due_beats.pop_front();
      if (data !== want.data || stat !== want.stat)
        record_fail($sformatf("mismatch: expected data %h status %0d, got data %h status %0d",
                              want.data, want.stat, data, stat));
    endfunction

    function void flush_check();
      if (due_beats.size() != 0)
        record_fail($sformatf("%0d result beats never arrived", due_beats.size()));
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for gather_backward_scatter_add_unit: directed corner items,
// then randomized phases under several register settings with random stalls.
// Depends on gbsa_pkg, gbsa_tb_pkg and the unit itself.
`timescale 1ns / 1ps
module tb;
  import gbsa_pkg::*;
  import gbsa_tb_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int IDLE_PCT    = 14;
  localparam int PHASE_ITEMS = 125;
  // A start item sweeps the whole accumulator, so a correct run can stay quiet
  // for the length of that sweep; the limit leaves wide margin.
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [DATA_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] GRAD_MIN = 32'sh8000_0000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                func = FN_START;
  logic [CNT_W-1:0]          position = '0;
  logic signed [DATA_W-1:0]  index_value = '0;
  logic signed [DATA_W-1:0]  grad_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  read_data;
  logic [1:0]                status;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = REG_OUTER;
  logic [CFG_W-1:0]          cfg_data = '0;

  // When set, neither side inserts idle cycles.
  bit                        steady_run = 1'b0;
  int                        quiet_cycles = 0;
  scatter_add_board          sb;

  gather_backward_scatter_add_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .position    (position),
    .index_value (index_value),
    .grad_value  (grad_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: check every accepted beat against the oldest prediction, then
  // choose the stall for the next cycle. Stall never waits on valid.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(read_data, status);
    out_stall <= !rst && !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: any cycle without a beat on some channel counts toward the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, after an optional random gap, and hold it until the unit
  // takes it. Valid is left high so a following item goes out back to back.
  // The prediction is made at the edge where the beat is accepted.
  task automatic send_item(func_t f, logic [CNT_W-1:0] pos,
                           logic signed [DATA_W-1:0] ival,
                           logic signed [DATA_W-1:0] gval);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    position    <= pos;
    index_value <= ival;
    grad_value  <= gval;
    do @(posedge clk); while (in_stall);
    sb.note_item(f, pos, ival, gval);
  endtask

  // Stop sending and wait until every predicted beat has come back. Every item
  // yields exactly one beat, so the unit is idle once the queue is empty.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Write all four dimension registers in index order, back to back.
  task automatic write_dims(logic [CFG_W-1:0] oc, logic [CFG_W-1:0] ax,
                            logic [CFG_W-1:0] ic, logic [CFG_W-1:0] nc);
    logic [CFG_W-1:0] vals [4];
    vals = '{oc, ax, ic, nc};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(reg_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly a valid slot on the gather axis, sometimes one that must be skipped.
  function automatic logic signed [DATA_W-1:0] pick_index(longint ax);
    case ($urandom_range(0, 19))
      0: return -1;
      1: return DATA_W'(ax);
      2: return GRAD_MIN;
      3: return $urandom;
      default: return $urandom_range(0, ax - 1);
    endcase
  endfunction

  // Small values accumulate cleanly; extremes and full-range values drive the
  // sums into saturation.
  function automatic logic signed [DATA_W-1:0] pick_grad();
    case ($urandom_range(0, 9))
      0: return GRAD_MAX;
      1: return GRAD_MIN;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  // One randomized phase: program the dimensions, clear, preload the first
  // index slots, then a stream that is mostly gradient beats in flat order
  // with reads, reloads, the odd start, pauses and some malformed items.
  task automatic random_phase(int unsigned budget,
                              logic [CFG_W-1:0] oc, logic [CFG_W-1:0] ax,
                              logic [CFG_W-1:0] ic, logic [CFG_W-1:0] nc);
    int unsigned sent;
    int unsigned pick;
    longint      span;
    longint      axis;
    func_t       f;
    drain();
    write_dims(oc, ax, ic, nc);
    axis = sb.dim(REG_AXIS);
    span = sb.dim(REG_OUTER) * axis * sb.dim(REG_INNER);
    if (span > ACC_DEPTH_DEF) span = ACC_DEPTH_DEF;
    send_item(FN_START, $urandom, $urandom, $urandom);
    sent = 1;
    for (int s = 0; s < sb.dim(REG_INDEX) && s < 16; s++) begin
      send_item(FN_LOAD, s, pick_index(axis), $urandom);
      sent++;
    end
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        // Pause the sender until every outstanding result is back.
        drain();
      end else begin
        sent++;
        if (pick < 69) begin
          // A gradient whose slot was never loaded would read an undefined
          // table entry, so that slot is loaded instead.
          if (sb.slot_ready()) send_item(FN_GRAD, $urandom, $urandom, pick_grad());
          else send_item(FN_LOAD, sb.cur_slot(), pick_index(axis), $urandom);
        end else if (pick < 79) begin
          send_item(FN_READ,
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, span - 1),
                    $urandom, $urandom);
        end else if (pick < 87) begin
          send_item(FN_LOAD, $urandom_range(0, sb.dim(REG_INDEX) - 1), pick_index(axis),
                    $urandom);
        end else if (pick < 89) begin
          send_item(FN_START, $urandom, $urandom, $urandom);
        end else begin
          // Noise: any function with fully random fields.
          f = func_t'($urandom_range(0, 3));
          if (f == FN_GRAD && !sb.slot_ready()) f = FN_LOAD;
          send_item(f, $urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The accumulator is swept clean after reset while the input is stalled.
    do @(posedge clk); while (in_stall);

    // Directed part. With one outer position, one slot and unit inner size,
    // every gradient lands on the entry named by slot zero.
    write_dims(1, 2, 1, 1);
    send_item(FN_START, '0, '0, '0);
    send_item(FN_LOAD, 0, 1, '0);
    send_item(FN_GRAD, '0, '0, GRAD_MAX);
    send_item(FN_GRAD, '0, '0, GRAD_MAX);       // positive saturation
    send_item(FN_READ, 1, '0, '0);
    send_item(FN_GRAD, '0, '0, GRAD_MIN);       // back to minus one
    send_item(FN_GRAD, '0, '0, GRAD_MIN);       // negative saturation
    send_item(FN_READ, 1, '0, '0);
    send_item(FN_GRAD, '0, '0, '0);
    // Negative index, index equal to the axis size and the most negative
    // index are all skipped while the counters still move.
    send_item(FN_LOAD, 0, -1, '0);
    send_item(FN_GRAD, '0, '0, 5);
    send_item(FN_LOAD, 0, 2, '0);
    send_item(FN_GRAD, '0, '0, 5);
    send_item(FN_LOAD, 0, GRAD_MIN, '0);
    send_item(FN_GRAD, '0, GRAD_MAX, GRAD_MAX);
    // Loads past the end of the index table are refused.
    send_item(FN_LOAD, INDEX_DEPTH_DEF, GRAD_MAX, '0);
    send_item(FN_LOAD, {CNT_W{1'b1}}, GRAD_MAX, '1);
    send_item(FN_READ, {CNT_W{1'b1}}, '1, '1);

    // Every register above its maximum: the computed address runs past the
    // end of the accumulator.
    drain();
    write_dims({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
    send_item(FN_LOAD, 0, 1, '0);
    send_item(FN_GRAD, '0, '0, 7);
    send_item(FN_GRAD, '0, '0, 7);

    // Every register zero, which counts as one.
    drain();
    write_dims('0, '0, '0, '0);
    send_item(FN_GRAD, '0, '0, 9);
    send_item(FN_LOAD, 0, 0, '0);
    send_item(FN_GRAD, '0, '0, 9);
    send_item(FN_START, '1, '1, '1);
    send_item(FN_READ, 0, '0, '0);

    // Randomized phases: the smallest shape, the widest axis and table, the
    // longest outer run, a shape that fills the memory exactly, one that
    // overruns it (with no idling on either side), then random shapes.
    random_phase(PHASE_ITEMS, 1, 1, 1, 1);
    random_phase(PHASE_ITEMS, 1, DIM_MAX, INDEX_DEPTH_DEF, 1);
    random_phase(PHASE_ITEMS, DIM_MAX, 1, 1, 1);
    random_phase(PHASE_ITEMS, 16, 16, 8, 16);
    steady_run = 1'b1;
    random_phase(PHASE_ITEMS, 8, 64, 4, 16);
    steady_run = 1'b0;
    for (int k = 0; k < 4; k++) begin
      random_phase(PHASE_ITEMS, $urandom_range(0, 8), $urandom_range(1, 24),
                   ($urandom_range(0, 5) == 0) ? {CFG_W{1'b1}} : $urandom_range(0, 20),
                   $urandom_range(0, 8));
    end

    // Let the last beats come back, then keep watching the result channel in
    // case the unit produces anything it should not.
    drain();
    repeat (16) @(posedge clk);
    sb.flush_check();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
design/gbsa_pkg.sv
design/gbsa_ram.sv
design/gather_backward_scatter_add_unit.sv
tb/gbsa_tb_pkg.sv
tb/tb.sv
